/* design/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

  localparam int BLOCK_COUNT     = 4096;
  localparam int BLOCK_BYTES     = 4096;
  localparam int RESERVED_BLOCKS = 256;

  // Blocks actually reserved at reset can never exceed the block count.
  localparam int RSV_BLOCKS  = (RESERVED_BLOCKS > BLOCK_COUNT) ? BLOCK_COUNT : RESERVED_BLOCKS;
  localparam int MAP_WORDS   = (BLOCK_COUNT + 31) / 32;
  localparam int WIDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BLK_W       = WIDX_W + 5;
  localparam int COUNT_W     = $clog2(BLOCK_COUNT + 1);
  // The block size is a power of two, so block arithmetic is a shift.
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic alloc_wr;
    logic nomem;
    logic free_rd;
    logic free_wr;
    logic set_range;
    logic set_already;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic range_err;
    logic bit_used;
    logic out_busy;
  } sts_t;

  // Contents of a map word before it is first written: reserved blocks are
  // used, and bits past the last block read as used so they are never handed out.
  function automatic logic [31:0] reset_word(input logic [WIDX_W-1:0] w);
    logic [31:0] word;
    int          idx;
    word = '0;
    for (int b = 0; b < 32; b++) begin
      idx = int'(w) * 32 + b;
      word[b] = (idx < RSV_BLOCKS) || (idx >= BLOCK_COUNT);
    end
    return word;
  endfunction

endpackage

/* design/bba_ram.sv */
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/bba_datapath.sv */
`timescale 1ns / 1ps

module bba_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bba_pkg::cmd_t                     cmd,
  output bba_pkg::sts_t                     sts,
  input  logic [bba_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]    out_tdata
);

  logic [31:0]                      addr_r, addr_nxt;
  logic [bba_pkg::WIDX_W:0]         ptr_r, ptr_nxt;
  logic                             chk_vld_r, chk_vld_nxt;
  logic [bba_pkg::WIDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                             rd_vld_r, rd_vld_nxt;
  logic [bba_pkg::MAP_WORDS-1:0]    valid_r, valid_nxt;
  logic [bba_pkg::COUNT_W-1:0]      used_r, used_nxt;
  logic [bba_pkg::COUNT_W-1:0]      free_r, free_nxt;
  logic [1:0]                       res_status_r, res_status_nxt;
  logic [23:0]                      res_baddr_r, res_baddr_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [bba_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  logic                             rd_en;
  logic [bba_pkg::WIDX_W-1:0]       rd_addr;
  logic [31:0]                      rd_data;
  logic                             wr_en;
  logic [31:0]                      wr_data;
  logic [31:0]                      eff_word;
  logic                             any_zero;
  logic [4:0]                       zero_bit;
  logic [31:0]                      blk_full;
  logic [4:0]                       free_bit;
  logic                             ptr_live;
  logic [39:0]                      alloc_addr;

  assign blk_full = addr_r >> bba_pkg::BLOCK_SHIFT;
  assign free_bit = blk_full[4:0];
  assign ptr_live = (ptr_r < (bba_pkg::WIDX_W + 1)'(bba_pkg::MAP_WORDS));

  // Words never written since reset come from the reset pattern.
  assign eff_word = rd_vld_r ? rd_data : bba_pkg::reset_word(chk_idx_r);

  always_comb begin
    any_zero = 1'b0;
    zero_bit = '0;
    for (int b = 31; b >= 0; b--) begin
      if (!eff_word[b]) begin
        any_zero = 1'b1;
        zero_bit = 5'(b);
      end
    end
  end

  assign alloc_addr = {{(40 - bba_pkg::BLK_W){1'b0}}, chk_idx_r, zero_bit}
                      << bba_pkg::BLOCK_SHIFT;

  assign rd_en   = (cmd.scan && ptr_live) || cmd.free_rd;
  assign rd_addr = cmd.free_rd ? blk_full[bba_pkg::BLK_W-1:5] : ptr_r[bba_pkg::WIDX_W-1:0];
  assign wr_en   = cmd.alloc_wr || cmd.free_wr;

  always_comb begin
    if (cmd.alloc_wr) begin
      wr_data = eff_word | (32'd1 << zero_bit);
    end else begin
      wr_data = eff_word & ~(32'd1 << free_bit);
    end
  end

  bba_ram #(
    .WIDTH (32),
    .DEPTH (bba_pkg::MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (chk_idx_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    addr_nxt       = addr_r;
    ptr_nxt        = ptr_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    rd_vld_nxt     = rd_vld_r;
    valid_nxt      = valid_r;
    used_nxt       = used_r;
    free_nxt       = free_r;
    res_status_nxt = res_status_r;
    res_baddr_nxt  = res_baddr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;

    if (cmd.start) begin
      addr_nxt    = in_tdata;
      ptr_nxt     = '0;
      chk_vld_nxt = 1'b0;
    end
    if (cmd.scan) begin
      ptr_nxt     = ptr_live ? ptr_r + 1'b1 : ptr_r;
      chk_vld_nxt = ptr_live;
    end
    if (rd_en) begin
      chk_idx_nxt = rd_addr;
      rd_vld_nxt  = valid_r[rd_addr];
    end
    if (wr_en) begin
      valid_nxt[chk_idx_r] = 1'b1;
    end
    if (cmd.alloc_wr) begin
      used_nxt       = used_r + 1'b1;
      free_nxt       = free_r - 1'b1;
      res_status_nxt = bba_pkg::ST_OK;
      res_baddr_nxt  = alloc_addr[23:0];
    end
    if (cmd.free_wr) begin
      used_nxt       = used_r - 1'b1;
      free_nxt       = free_r + 1'b1;
      res_status_nxt = bba_pkg::ST_OK;
      res_baddr_nxt  = '0;
    end
    if (cmd.nomem) begin
      res_status_nxt = bba_pkg::ST_NOMEM;
      res_baddr_nxt  = '0;
    end
    if (cmd.set_range) begin
      res_status_nxt = bba_pkg::ST_RANGE;
      res_baddr_nxt  = '0;
    end
    if (cmd.set_already) begin
      res_status_nxt = bba_pkg::ST_FREE;
      res_baddr_nxt  = '0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'd0, 13'(free_r), 13'(used_r), res_baddr_r, res_status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      used_r      <= bba_pkg::COUNT_W'(bba_pkg::RSV_BLOCKS);
      free_r      <= bba_pkg::COUNT_W'(bba_pkg::BLOCK_COUNT - bba_pkg::RSV_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      used_r      <= used_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    chk_idx_r    <= chk_idx_nxt;
    rd_vld_r     <= rd_vld_nxt;
    res_status_r <= res_status_nxt;
    res_baddr_r  <= res_baddr_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign sts.hit       = chk_vld_r && any_zero;
  assign sts.exhausted = chk_vld_r && !any_zero &&
                         (chk_idx_r == bba_pkg::WIDX_W'(bba_pkg::MAP_WORDS - 1));
  assign sts.range_err = (blk_full >= 32'(bba_pkg::BLOCK_COUNT));
  assign sts.bit_used  = eff_word[free_bit];
  assign sts.out_busy  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/bba_ctrl.sv */
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_tuser,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  bba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bba_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = in_tuser ? bba_pkg::S_FREE_RD : bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.alloc_wr = 1'b1;
          state_nxt    = bba_pkg::S_FINISH;
        end else if (sts.exhausted) begin
          cmd.nomem = 1'b1;
          state_nxt = bba_pkg::S_FINISH;
        end
      end
      bba_pkg::S_FREE_RD: begin
        if (sts.range_err) begin
          cmd.set_range = 1'b1;
          state_nxt     = bba_pkg::S_FINISH;
        end else begin
          cmd.free_rd = 1'b1;
          state_nxt   = bba_pkg::S_FREE_CHK;
        end
      end
      bba_pkg::S_FREE_CHK: begin
        if (sts.bit_used) begin
          cmd.free_wr = 1'b1;
        end else begin
          cmd.set_already = 1'b1;
        end
        state_nxt = bba_pkg::S_FINISH;
      end
      bba_pkg::S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* design/bitmap_block_allocator_core.sv */
`timescale 1ns / 1ps

// First-fit block allocator over a used/free bitmap of 4096 blocks of 4096 bytes,
// held as 128 words of 32 bits in a single RAM; the lowest 256 blocks start used.
// A word with tuser low allocates the lowest free block and returns its byte
// address; a word with tuser high frees the block holding the address in tdata.
// Every result carries status and the used and free counts after the step.
// An allocation reads one map word per cycle from the lowest upwards up to the
// first word with a free bit, or reports no memory when no word has one. A free
// reads the word of the block and clears its bit, or reports a range error when
// the address lies past the last block, or that the block is already free. One
// request is worked at a time; a new request is taken while the previous result
// waits on the output register. No clearing pass is needed after reset.

module bitmap_block_allocator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bba_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] address
  input  logic                           in_tuser,   // [0] opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0] out_tdata   // [1:0] status, [25:2] block_address,
                                                     // [38:26] used_count,
                                                     // [51:39] free_count, [55:52] zero
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  bba_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
